// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the waiting queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define WQP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define WQP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wqp_pkg.sv =====
// Shared constants, codes and types of the waiting queue.
`timescale 1ns / 1ps
`default_nettype none

package wqp_pkg;

    localparam int DEPTH    = 16;
    localparam int ID_BITS  = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int REQ_W    = 2;
    localparam int IN_ID_W  = 16;
    localparam int OUT_ID_W = 16;
    localparam int STAT_W   = 3;
    localparam int OCC_W    = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND  = 2'd0,
        REQ_REMOVE  = 2'd1,
        REQ_PROMOTE = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_AT_HEAD   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_SWAP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_ctl_t;

    typedef struct packed {
        status_t              status;
        logic [OCC_W-1:0]     occupancy;
        logic [OUT_ID_W-1:0]  head_id;
    } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/waiting_queue_with_promote.sv =====
// Top level of the waiting queue: request channel, result register, checks.
// Usage:
//   Request channel: req_type and client_id, taken at a clock edge where
//   in_valid is high and in_stall is low. in_stall stays high while a
//   request is being worked on; one request is in flight at a time.
//   Result channel: status, occupancy and head_id, one beat per request,
//   taken where out_valid is high and out_stall is low.
// Request handling (n = entries held before the request):
//   append, rejected requests and code 3 go straight to the result.
//   remove scans n-1 entries; promote scans up to n-1 entries, then swaps.
//   Every step of the scan is one store read and one compare.
//   The sequencer returns to idle as the result moves to the output
//   register, so a new request can be taken while a result waits there.
// Reset clears the queue to empty and drops any pending result. If the
// receiver stalls, the result holds and the sequencer waits with the next
// result until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module waiting_queue_with_promote (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_stall,
    input  wire logic [wqp_pkg::REQ_W-1:0]     req_type,
    input  wire logic [wqp_pkg::IN_ID_W-1:0]   client_id,
    output      logic                          out_valid,
    input  wire logic                          out_stall,
    output      logic [wqp_pkg::STAT_W-1:0]    status,
    output      logic [wqp_pkg::OCC_W-1:0]     occupancy,
    output      logic [wqp_pkg::OUT_ID_W-1:0]  head_id
);

    wqp_pkg::core_ctl_t  ctl;
    wqp_pkg::res_t       res;
    logic                res_ready;
    logic                start;
    logic                out_valid_reg, out_valid_next;
    wqp_pkg::res_t       out_res_reg, out_res_next;

    assign in_stall  = !ctl.idle;
    assign start     = in_valid && ctl.idle;
    assign res_ready = !out_valid_reg || !out_stall;

    wqp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .client_id (client_id),
        .res_ready (res_ready),
        .ctl       (ctl),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_ready)
        begin
            out_valid_next = ctl.res_valid;
            if (ctl.res_valid)
            begin
                out_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_res_reg.status;
    assign occupancy = out_res_reg.occupancy;
    assign head_id   = out_res_reg.head_id;

    `WQP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "sequencer did not go busy after a request beat")
    `WQP_ASSERT(a_occ_bound, clk, rst_n, !out_valid || (occupancy <= wqp_pkg::OCC_W'(wqp_pkg::DEPTH)), "occupancy above depth")
    `WQP_ASSERT(a_empty_result, clk, rst_n, !out_valid || (status != wqp_pkg::ST_EMPTY) || ((occupancy == '0) && (head_id == '0)), "empty status with entries held")
    `WQP_ASSERT(a_full_result, clk, rst_n, !out_valid || (status != wqp_pkg::ST_FULL) || (occupancy == wqp_pkg::OCC_W'(wqp_pkg::DEPTH)), "full status with room left")

endmodule

`default_nettype wire

// ===== hw/rtl/wqp_core.sv =====
// Queue store and request sequencer: the scan reads and compares one entry per step.
`timescale 1ns / 1ps
`default_nettype none

module wqp_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [wqp_pkg::REQ_W-1:0]    req_type,
    input  wire logic [wqp_pkg::IN_ID_W-1:0]  client_id,
    input  wire logic                         res_ready,
    output wqp_pkg::core_ctl_t                ctl,
    output wqp_pkg::res_t                     res
);

    wqp_pkg::state_t                   state_reg, state_next;
    wqp_pkg::req_t                     req_reg, req_next;
    wqp_pkg::status_t                  status_reg, status_next;
    logic [wqp_pkg::ID_BITS-1:0]       id_reg, id_next;
    logic [wqp_pkg::ID_BITS-1:0]       prev_reg, prev_next;
    logic [wqp_pkg::ID_BITS-1:0]       head_reg, head_next;
    logic [wqp_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [wqp_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [wqp_pkg::ID_BITS-1:0]       rd_data_reg;

    logic [wqp_pkg::ID_BITS-1:0]       mem [wqp_pkg::DEPTH];

    logic                              wr_en;
    logic [wqp_pkg::ADDR_W-1:0]        wr_addr;
    logic [wqp_pkg::ID_BITS-1:0]       wr_data;

    wqp_pkg::req_t                     req_in;
    logic [wqp_pkg::ID_BITS-1:0]       id_in;
    logic                              need_scan;
    logic                              last;
    logic                              match;

    assign req_in = wqp_pkg::req_t'(req_type);
    assign id_in  = wqp_pkg::ID_BITS'(client_id);

    // remove with more than one entry shifts; promote past the head scans
    assign need_scan = (count_reg > wqp_pkg::CNT_W'(1)) &&
                       ((req_in == wqp_pkg::REQ_REMOVE) ||
                        ((req_in == wqp_pkg::REQ_PROMOTE) && (head_reg != id_in)));
    assign last  = (wqp_pkg::CNT_W'(addr_reg) + wqp_pkg::CNT_W'(1)) == count_reg;
    assign match = (rd_data_reg == id_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wqp_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        id_reg     <= id_next;
        prev_reg   <= prev_next;
        head_reg   <= head_next;
        addr_reg   <= addr_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wqp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = need_scan ? wqp_pkg::S_RD : wqp_pkg::S_DONE;
                end
            end
            wqp_pkg::S_RD:
            begin
                state_next = wqp_pkg::S_CHK;
            end
            wqp_pkg::S_CHK:
            begin
                if (req_reg == wqp_pkg::REQ_PROMOTE && match)
                begin
                    state_next = wqp_pkg::S_SWAP;
                end
                else
                begin
                    state_next = last ? wqp_pkg::S_DONE : wqp_pkg::S_RD;
                end
            end
            wqp_pkg::S_SWAP:
            begin
                state_next = wqp_pkg::S_DONE;
            end
            wqp_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = wqp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wqp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_next    = req_reg;
        status_next = status_reg;
        id_next     = id_reg;
        prev_next   = prev_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        wr_en       = 1'b0;
        wr_addr     = addr_reg;
        wr_data     = rd_data_reg;
        case (state_reg)
            wqp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req_in;
                    id_next     = id_in;
                    status_next = wqp_pkg::ST_DONE;
                    case (req_in)
                        wqp_pkg::REQ_APPEND:
                        begin
                            if (count_reg == wqp_pkg::CNT_W'(wqp_pkg::DEPTH))
                            begin
                                status_next = wqp_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = count_reg[wqp_pkg::ADDR_W-1:0];
                                wr_data = id_in;
                                if (count_reg == '0)
                                begin
                                    head_next = id_in;
                                end
                                count_next = count_reg + wqp_pkg::CNT_W'(1);
                            end
                        end
                        wqp_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = wqp_pkg::ST_EMPTY;
                            end
                            else if (count_reg == wqp_pkg::CNT_W'(1))
                            begin
                                count_next = '0;
                            end
                            else
                            begin
                                addr_next = wqp_pkg::ADDR_W'(1);
                            end
                        end
                        wqp_pkg::REQ_PROMOTE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = wqp_pkg::ST_NOT_FOUND;
                            end
                            else if (head_reg == id_in)
                            begin
                                status_next = wqp_pkg::ST_AT_HEAD;
                            end
                            else
                            begin
                                status_next = wqp_pkg::ST_NOT_FOUND;
                                prev_next   = head_reg;
                                addr_next   = wqp_pkg::ADDR_W'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            wqp_pkg::S_CHK:
            begin
                if (req_reg == wqp_pkg::REQ_REMOVE)
                begin
                    // shift entry forward by one place
                    wr_en   = 1'b1;
                    wr_addr = addr_reg - wqp_pkg::ADDR_W'(1);
                    wr_data = rd_data_reg;
                    if (addr_reg == wqp_pkg::ADDR_W'(1))
                    begin
                        head_next = rd_data_reg;
                    end
                    if (last)
                    begin
                        count_next = count_reg - wqp_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        addr_next = addr_reg + wqp_pkg::ADDR_W'(1);
                    end
                end
                else if (match)
                begin
                    // first half of the swap: predecessor moves back
                    wr_en       = 1'b1;
                    wr_addr     = addr_reg;
                    wr_data     = prev_reg;
                    status_next = wqp_pkg::ST_DONE;
                    if (addr_reg == wqp_pkg::ADDR_W'(1))
                    begin
                        head_next = id_reg;
                    end
                end
                else
                begin
                    prev_next = rd_data_reg;
                    if (!last)
                    begin
                        addr_next = addr_reg + wqp_pkg::ADDR_W'(1);
                    end
                end
            end
            wqp_pkg::S_SWAP:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg - wqp_pkg::ADDR_W'(1);
                wr_data = id_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign ctl.idle      = (state_reg == wqp_pkg::S_IDLE);
    assign ctl.res_valid = (state_reg == wqp_pkg::S_DONE);

    assign res.status    = status_reg;
    assign res.occupancy = wqp_pkg::OCC_W'(count_reg);
    assign res.head_id   = (count_reg == '0) ? '0 : wqp_pkg::OUT_ID_W'(head_reg);

endmodule

`default_nettype wire
